@@ rtl/core/hsv2rgb_pkg.sv @@
package hsv2rgb_pkg;

    localparam logic [8:0] HUE_FULL_TURN = 9'd360;
    localparam logic [8:0] SECTOR_SPAN   = 9'd60;
    localparam logic [7:0] LEVEL_MAX     = 8'd255;

    // sector codes, one per 60 degree slice of the hue circle
    localparam logic [2:0] SEC_RED_YEL = 3'd0;
    localparam logic [2:0] SEC_YEL_GRN = 3'd1;
    localparam logic [2:0] SEC_GRN_CYN = 3'd2;
    localparam logic [2:0] SEC_CYN_BLU = 3'd3;
    localparam logic [2:0] SEC_BLU_MAG = 3'd4;
    localparam logic [2:0] SEC_MAG_RED = 3'd5;

    typedef struct packed {
        logic [2:0] sector;
        logic [5:0] rem;
    } t_hue_pos;

    // exact floor(x / 255) for x up to 255 * 255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] sum;
        sum = {1'b0, x} + 17'(x[15:8]) + 17'd1;
        return sum[15:8];
    endfunction

endpackage

@@ rtl/core/hsv2rgb_hue_split.sv @@
module hsv2rgb_hue_split (
    input  logic [8:0]            i_hue,
    output hsv2rgb_pkg::t_hue_pos o_pos
);
    import hsv2rgb_pkg::*;

    logic [2:0] n_sector;
    logic [8:0] n_base;
    logic [8:0] n_diff;

    // hue is already below a full turn here
    always_comb begin
        if (i_hue >= 9'(5 * SECTOR_SPAN)) begin
            n_sector = SEC_MAG_RED;
        end else if (i_hue >= 9'(4 * SECTOR_SPAN)) begin
            n_sector = SEC_BLU_MAG;
        end else if (i_hue >= 9'(3 * SECTOR_SPAN)) begin
            n_sector = SEC_CYN_BLU;
        end else if (i_hue >= 9'(2 * SECTOR_SPAN)) begin
            n_sector = SEC_GRN_CYN;
        end else if (i_hue >= SECTOR_SPAN) begin
            n_sector = SEC_YEL_GRN;
        end else begin
            n_sector = SEC_RED_YEL;
        end
    end

    always_comb begin
        case (n_sector)
            SEC_RED_YEL: n_base = 9'd0;
            SEC_YEL_GRN: n_base = SECTOR_SPAN;
            SEC_GRN_CYN: n_base = 9'(2 * SECTOR_SPAN);
            SEC_CYN_BLU: n_base = 9'(3 * SECTOR_SPAN);
            SEC_BLU_MAG: n_base = 9'(4 * SECTOR_SPAN);
            default:     n_base = 9'(5 * SECTOR_SPAN);
        endcase
    end

    assign n_diff       = i_hue - n_base;
    assign o_pos.sector = n_sector;
    assign o_pos.rem    = n_diff[5:0];

endmodule

@@ rtl/core/hsv_to_rgb_converter_unit.sv @@
// an accepted input word is registered in turn by stages 0 to 6 before the result word reaches the output
// throughput: one pixel per cycle while the output is not stalled, seven register stages each with its own valid bit
// a stalled output only holds the stages that are full; empty stages keep filling
// reset (synchronous, active low) clears all valid bits; payload registers are not reset
module hsv_to_rgb_converter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // hue[8:0], saturation[16:9], brightness_value[24:17]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata    // red[7:0], green[15:8], blue[23:16]
);
    import hsv2rgb_pkg::*;

    localparam int NSTG = 7;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_ld;

    logic [8:0] i_hue;
    logic [7:0] i_sat;
    logic [7:0] i_val;
    assign i_hue = i_s_tdata[8:0];
    assign i_sat = i_s_tdata[16:9];
    assign i_val = i_s_tdata[24:17];

    // a stage loads when it is empty or the stage after it moves on
    always_comb begin
        w_ld[NSTG-1] = !r_vld[NSTG-1] || i_m_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_ld[k] = !r_vld[k] || w_ld[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_ld[0]) begin
                r_vld[0] <= i_s_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_ld[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 0: hue wrap
    logic [8:0] r_h1, n_h1;
    logic [7:0] r_s1, r_b1;
    assign n_h1 = (i_hue >= HUE_FULL_TURN) ? i_hue - HUE_FULL_TURN : i_hue;

    always_ff @(posedge i_clk) begin
        if (w_ld[0]) begin
            r_h1 <= n_h1;
            r_s1 <= i_sat;
            r_b1 <= i_val;
        end
    end

    // stage 1: sector split, v*(255-s)
    t_hue_pos    n_pos;
    logic [2:0]  r_sec2;
    logic [5:0]  r_rem2;
    logic [7:0]  r_s2, r_b2;
    logic [15:0] r_pp2, n_pp2;

    hsv2rgb_hue_split u_hue_split (
        .i_hue (r_h1),
        .o_pos (n_pos)
    );

    assign n_pp2 = 16'(r_b1) * 16'(LEVEL_MAX - r_s1);

    always_ff @(posedge i_clk) begin
        if (w_ld[1]) begin
            r_sec2 <= n_pos.sector;
            r_rem2 <= n_pos.rem;
            r_s2   <= r_s1;
            r_b2   <= r_b1;
            r_pp2  <= n_pp2;
        end
    end

    // stage 2: frac = rem*255/60 = rem*17/4, p = pp/255
    logic [9:0] n_rem17;
    logic [7:0] r_frac3, r_s3, r_b3, r_p3;
    logic [2:0] r_sec3;
    assign n_rem17 = 10'(r_rem2) * 10'd17;

    always_ff @(posedge i_clk) begin
        if (w_ld[2]) begin
            r_frac3 <= n_rem17[9:2];
            r_sec3  <= r_sec2;
            r_s3    <= r_s2;
            r_b3    <= r_b2;
            r_p3    <= div255(r_pp2);
        end
    end

    // stage 3: s*frac and s*(255-frac)
    logic [15:0] r_sq4, r_st4;
    logic [2:0]  r_sec4;
    logic [7:0]  r_b4, r_p4;

    always_ff @(posedge i_clk) begin
        if (w_ld[3]) begin
            r_sq4  <= 16'(r_s3) * 16'(r_frac3);
            r_st4  <= 16'(r_s3) * 16'(LEVEL_MAX - r_frac3);
            r_sec4 <= r_sec3;
            r_b4   <= r_b3;
            r_p4   <= r_p3;
        end
    end

    // stage 4: 255 - x/255
    logic [7:0] r_qa5, r_ta5, r_b5, r_p5;
    logic [2:0] r_sec5;

    always_ff @(posedge i_clk) begin
        if (w_ld[4]) begin
            r_qa5  <= LEVEL_MAX - div255(r_sq4);
            r_ta5  <= LEVEL_MAX - div255(r_st4);
            r_sec5 <= r_sec4;
            r_b5   <= r_b4;
            r_p5   <= r_p4;
        end
    end

    // stage 5: scale by value
    logic [15:0] r_qp6, r_tp6;
    logic [7:0]  r_b6, r_p6;
    logic [2:0]  r_sec6;

    always_ff @(posedge i_clk) begin
        if (w_ld[5]) begin
            r_qp6  <= 16'(r_b5) * 16'(r_qa5);
            r_tp6  <= 16'(r_b5) * 16'(r_ta5);
            r_sec6 <= r_sec5;
            r_b6   <= r_b5;
            r_p6   <= r_p5;
        end
    end

    // stage 6: q, t and the sector permutation into the output register
    // zero saturation makes p, q and t all equal v, so grey needs no special path
    logic [7:0] n_q, n_t;
    logic [7:0] n_red, n_green, n_blue;
    logic [7:0] r_red, r_green, r_blue;
    assign n_q = div255(r_qp6);
    assign n_t = div255(r_tp6);

    always_comb begin
        case (r_sec6)
            SEC_RED_YEL: begin n_red = r_b6; n_green = n_t;  n_blue = r_p6; end
            SEC_YEL_GRN: begin n_red = n_q;  n_green = r_b6; n_blue = r_p6; end
            SEC_GRN_CYN: begin n_red = r_p6; n_green = r_b6; n_blue = n_t;  end
            SEC_CYN_BLU: begin n_red = r_p6; n_green = n_q;  n_blue = r_b6; end
            SEC_BLU_MAG: begin n_red = n_t;  n_green = r_p6; n_blue = r_b6; end
            default:     begin n_red = r_b6; n_green = r_p6; n_blue = n_q;  end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[6]) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_s_tready = w_ld[0];
    assign o_m_tvalid = r_vld[NSTG-1];
    assign o_m_tdata  = {r_blue, r_green, r_red};

    // an empty output register means the whole pipe can move
    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled while output register is empty");

    a_sector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> (r_sec3 <= SEC_MAG_RED))
        else $error("hue sector out of range");

    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> (r_frac3 <= 8'd250))
        else $error("sector fraction above 250");

    a_p_below_v: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> (r_p3 <= r_b3))
        else $error("p exceeds value");

endmodule
